@@ rtl/homogeneous_point_transform_defines.svh @@
// ----------------------------------------------------------------------------
// homogeneous point transform assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

// antecedent implies consequent on the same edge
`define HPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition never seen while out of reset
`define HPT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`endif

@@ rtl/hpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpt_pkg
// widths, mode codes and pipeline records of the point transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpt_pkg;

	localparam int QW        = 32;
	localparam int FRAC      = 16;
	localparam int NREG      = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 64;
	localparam int PROD_W    = 2 * QW;
	localparam int SUM_W     = PROD_W + 2;
	localparam int RES_W     = SUM_W - FRAC;
	localparam int MAG_W     = RES_W - 1;
	localparam int REM_W     = MAG_W + 1;
	localparam int DIV_STEPS = QW;
	localparam int LATENCY   = DIV_STEPS + 4;

	localparam logic [1:0] MODE_AFFINE = 2'd0;
	localparam logic [1:0] MODE_PERSP  = 2'd1;
	localparam logic [1:0] MODE_DIR    = 2'd2;

	localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	// identity matrix, highest register index first
	localparam logic [NREG-1:0][CFG_W-1:0] CFG_RESET = {
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
	};

	typedef logic [3:0][3:0][QW-1:0] matrix_t;

	typedef struct packed {
		logic [1:0]             mode;
		logic [3:0][RES_W-1:0]  col;
	} mac_res_t;

	typedef struct packed {
		logic                   divide;
		logic [2:0]             neg;
		logic [2:0]             ovf;
		logic [2:0][MAG_W-1:0]  mag;
		logic [MAG_W-1:0]       dvsr;
		logic [2:0][QW-1:0]     byp;
		logic                   byp_sat;
	} div_req_t;

endpackage

@@ rtl/hpt_mac.sv @@
// ----------------------------------------------------------------------------
// hpt_mac
// two stage multiply and column sum, rounded half up to Q16.16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpt_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [1:0]                   mode,
	input  logic signed [hpt_pkg::QW-1:0] vec_x,
	input  logic signed [hpt_pkg::QW-1:0] vec_y,
	input  logic signed [hpt_pkg::QW-1:0] vec_z,
	input  hpt_pkg::matrix_t             coef,
	output logic                         out_valid,
	output hpt_pkg::mac_res_t            res
);

	localparam logic signed [hpt_pkg::SUM_W-1:0] HALF =
		hpt_pkg::SUM_W'(1) << (hpt_pkg::FRAC - 1);

	logic signed [hpt_pkg::QW-1:0]     vec [0:2];
	logic                              vld_s1;
	logic [1:0]                        mode_s1;
	logic signed [hpt_pkg::PROD_W-1:0] prod_s1 [0:3][0:2];
	logic signed [hpt_pkg::QW-1:0]     tr_s1 [0:3];
	logic signed [hpt_pkg::SUM_W-1:0]  sum [0:3];
	logic                              vld_s2;
	hpt_pkg::mac_res_t                 res_s2;

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// one product per multiplier
	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		for (int c = 0; c < 4; c++) begin
			tr_s1[c] <= $signed(coef[3][c]);
			for (int r = 0; r < 3; r++) begin
				prod_s1[c][r] <= vec[r] * $signed(coef[r][c]);
			end
		end
	end

	// exact sum at Q34.32, translation skipped for directions (w always keeps it)
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c] = hpt_pkg::SUM_W'(prod_s1[c][0]) + hpt_pkg::SUM_W'(prod_s1[c][1])
				+ hpt_pkg::SUM_W'(prod_s1[c][2]) + HALF;
			if (mode_s1 != hpt_pkg::MODE_DIR || c == 3) begin
				sum[c] = sum[c] + (hpt_pkg::SUM_W'(tr_s1[c]) <<< hpt_pkg::FRAC);
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s2.mode <= mode_s1;
		for (int c = 0; c < 4; c++) begin
			res_s2.col[c] <= sum[c][hpt_pkg::SUM_W-1:hpt_pkg::FRAC];
		end
	end

	assign out_valid = vld_s2;
	assign res       = res_s2;

endmodule

@@ rtl/hpt_div.sv @@
// ----------------------------------------------------------------------------
// hpt_div
// three lane restoring divider, one quotient bit per stage, with final rounding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpt_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  hpt_pkg::div_req_t       req,
	output logic                    out_valid,
	output logic [hpt_pkg::QW-1:0]  res_x,
	output logic [hpt_pkg::QW-1:0]  res_y,
	output logic [hpt_pkg::QW-1:0]  res_z,
	output logic                    res_sat
);

	localparam int N = hpt_pkg::DIV_STEPS;

	logic                             vld_s [0:N];
	hpt_pkg::div_req_t                st_s  [0:N];
	logic [2:0][hpt_pkg::REM_W-1:0]   rem_s [0:N];
	logic [2:0][hpt_pkg::QW-1:0]      quo_s [0:N];

	// stage zero: partial remainder is the dividend above the quotient bits
	always_comb begin
		vld_s[0] = in_valid;
		st_s[0]  = req;
		for (int l = 0; l < 3; l++) begin
			rem_s[0][l] = hpt_pkg::REM_W'(req.mag[l] >> hpt_pkg::FRAC);
			quo_s[0][l] = '0;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		localparam int BIT = N - k;
		logic [2:0]                     nbit;
		logic [2:0][hpt_pkg::REM_W-1:0] part;
		logic [2:0][hpt_pkg::REM_W-1:0] nrem;
		logic [2:0]                     qbit;

		for (genvar l = 0; l < 3; l++) begin : g_lane
			if (BIT >= hpt_pkg::FRAC) begin : g_hi
				assign nbit[l] = st_s[k-1].mag[l][BIT-hpt_pkg::FRAC];
			end else begin : g_lo
				assign nbit[l] = 1'b0;
			end
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				part[l] = {rem_s[k-1][l][hpt_pkg::REM_W-2:0], nbit[l]};
				qbit[l] = part[l] >= {1'b0, st_s[k-1].dvsr};
				nrem[l] = qbit[l] ? part[l] - {1'b0, st_s[k-1].dvsr} : part[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			st_s[k] <= st_s[k-1];
			for (int l = 0; l < 3; l++) begin
				rem_s[k][l] <= nrem[l];
				quo_s[k][l] <= {quo_s[k-1][l][hpt_pkg::QW-2:0], qbit[l]};
			end
		end
	end

	logic [2:0][hpt_pkg::QW-1:0] lane;
	logic [2:0]                  lsat;
	logic [2:0][hpt_pkg::QW:0]   qr;
	logic                        flag;

	// round to nearest, ties away from zero, then apply sign and clamp; undivided points take the bypass value
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qr[l] = {1'b0, quo_s[N][l]} + (hpt_pkg::QW+1)'(
				{rem_s[N][l][hpt_pkg::REM_W-2:0], 1'b0} >= {1'b0, st_s[N].dvsr});
			lsat[l] = 1'b0;
			if (st_s[N].ovf[l]) begin
				lsat[l] = 1'b1;
				lane[l] = st_s[N].neg[l] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX;
			end else if (st_s[N].neg[l]) begin
				if (qr[l] > {1'b0, hpt_pkg::Q_MIN}) begin
					lsat[l] = 1'b1;
					lane[l] = hpt_pkg::Q_MIN;
				end else begin
					lane[l] = -qr[l][hpt_pkg::QW-1:0];
				end
			end else if (qr[l] > {1'b0, hpt_pkg::Q_MAX}) begin
				lsat[l] = 1'b1;
				lane[l] = hpt_pkg::Q_MAX;
			end else begin
				lane[l] = qr[l][hpt_pkg::QW-1:0];
			end
			if (!st_s[N].divide) begin
				lane[l] = st_s[N].byp[l];
			end
		end
		flag = st_s[N].divide ? |lsat : st_s[N].byp_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			res_sat   <= 1'b0;
		end else begin
			out_valid <= vld_s[N];
			res_sat   <= vld_s[N] & flag;
		end
	end

	always_ff @(posedge clk) begin
		res_x <= lane[0];
		res_y <= lane[1];
		res_z <= lane[2];
	end

endmodule

@@ rtl/homogeneous_point_transform.sv @@
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// Q16.16 row vector times 4x4 matrix, with optional perspective divide
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start / busy              req_type, in_x, in_y, in_z
//  result    done (one cycle strobe)   out_x, out_y, out_z, saturated
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one request per clock, busy stays low; every request gives one result
//  the pipeline runs multiply, column sum, divide setup, then the
//  32 stage divider (one quotient bit per stage) and the output register
//  reset clears the valid bits and loads the identity matrix
//  the result side cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homogeneous_point_transform (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic signed [hpt_pkg::QW-1:0]     in_x,
	input  logic signed [hpt_pkg::QW-1:0]     in_y,
	input  logic signed [hpt_pkg::QW-1:0]     in_z,
	output logic                              done,
	output logic signed [hpt_pkg::QW-1:0]     out_x,
	output logic signed [hpt_pkg::QW-1:0]     out_y,
	output logic signed [hpt_pkg::QW-1:0]     out_z,
	output logic                              saturated,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hpt_pkg::CFG_W-1:0]         cfg_data
);

	localparam logic signed [hpt_pkg::RES_W-1:0] R_ONE = hpt_pkg::RES_W'(1) << hpt_pkg::FRAC;
	localparam logic signed [hpt_pkg::RES_W-1:0] R_MAX = hpt_pkg::RES_W'(hpt_pkg::Q_MAX);
	localparam logic signed [hpt_pkg::RES_W-1:0] R_MIN = ~R_MAX;

	// matrix registers, identity after reset
	logic [hpt_pkg::NREG-1:0][hpt_pkg::CFG_W-1:0] cfg_q;
	hpt_pkg::matrix_t                             coef;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hpt_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready && cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NREG)) begin
			// out of range indexes are dropped
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// row r, column c sits in register 2r + c/2, odd columns in the upper half
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign coef[r][c] = cfg_q[2*r + c/2][hpt_pkg::QW*(c%2) +: hpt_pkg::QW];
		end
	end

	// stages 1 and 2: products and rounded column sums
	logic              mac_valid;
	hpt_pkg::mac_res_t mac_res;

	hpt_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.mode      (req_type),
		.vec_x     (in_x),
		.vec_y     (in_y),
		.vec_z     (in_z),
		.coef      (coef),
		.out_valid (mac_valid),
		.res       (mac_res)
	);

	// stage 3: divide setup (magnitudes, signs, overflow) and the no-divide result
	logic signed [hpt_pkg::RES_W-1:0] w;
	logic signed [hpt_pkg::RES_W-1:0] rc;
	logic [hpt_pkg::RES_W-1:0]        wabs;
	logic [hpt_pkg::RES_W-1:0]        rabs;
	hpt_pkg::div_req_t                dreq;
	logic                             vld_s3;
	hpt_pkg::div_req_t                dreq_s3;

	always_comb begin
		w           = $signed(mac_res.col[3]);
		wabs        = w[hpt_pkg::RES_W-1] ? -w : w;
		dreq        = '0;
		dreq.dvsr   = wabs[hpt_pkg::MAG_W-1:0];
		// w of exactly 1.0 or 0 leaves the point undivided
		dreq.divide = (mac_res.mode == hpt_pkg::MODE_PERSP) && (w != R_ONE) && (w != '0);
		for (int c = 0; c < 3; c++) begin
			rc              = $signed(mac_res.col[c]);
			rabs            = rc[hpt_pkg::RES_W-1] ? -rc : rc;
			dreq.mag[c]     = rabs[hpt_pkg::MAG_W-1:0];
			dreq.neg[c]     = rc[hpt_pkg::RES_W-1] ^ w[hpt_pkg::RES_W-1];
			// quotient of 2^32 or more always clamps
			dreq.ovf[c]     = {{hpt_pkg::FRAC{1'b0}}, dreq.mag[c]}
				>= {dreq.dvsr, {hpt_pkg::FRAC{1'b0}}};
			if (rc > R_MAX) begin
				dreq.byp[c]  = hpt_pkg::Q_MAX;
				dreq.byp_sat = 1'b1;
			end else if (rc < R_MIN) begin
				dreq.byp[c]  = hpt_pkg::Q_MIN;
				dreq.byp_sat = 1'b1;
			end else begin
				dreq.byp[c]  = rc[hpt_pkg::QW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= mac_valid;
		end
	end

	always_ff @(posedge clk) begin
		dreq_s3 <= dreq;
	end

	// divider stages and output register
	hpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.req       (dreq_s3),
		.out_valid (done),
		.res_x     (out_x),
		.res_y     (out_y),
		.res_z     (out_z),
		.res_sat   (saturated)
	);

endmodule

@@ rtl/hpt_checker.sv @@
// ----------------------------------------------------------------------------
// hpt_checker
// port level checks on request to result timing of the point transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "homogeneous_point_transform_defines.svh"

module hpt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic saturated
);

	`HPT_ASSERT_IMPLY(a_req_gives_result, clk, arst_n, start && !busy, ##(hpt_pkg::LATENCY) done)
	`HPT_ASSERT_IMPLY(a_result_has_req, clk, arst_n, done, $past(start && !busy, hpt_pkg::LATENCY))
	`HPT_ASSERT_NEVER(a_sat_without_result, clk, arst_n, saturated && !done)

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.saturated (saturated)
);

@@ dv/homogeneous_point_transform_test.sv @@
// ----------------------------------------------------------------------------
// homogeneous_point_transform_test
// self-checking bench: directed vectors at the identity and a scaled matrix,
// then random vectors under a series of matrices; results are checked against
// typed-in values or a local fixed-point model of the 4x4 transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homogeneous_point_transform_test;

	// register indexes of the matrix words
	typedef enum int {
		IDX_R0_C01 = 0, IDX_R0_C23 = 1, IDX_R1_C01 = 2, IDX_R1_C23 = 3,
		IDX_R2_C01 = 4, IDX_R2_C23 = 5, IDX_R3_C01 = 6, IDX_R3_C23 = 7
	} reg_idx_e;

	// matrix setups used by the random phases
	typedef enum int {
		MAT_RANDOM, MAT_ZERO, MAT_ALL_ONES, MAT_MAX, MAT_MIN, MAT_PERSP, MAT_W_ZERO
	} mat_kind_e;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [31:0] Q_ONE_C = 32'h0001_0000;
	// spare mode code, behaves as an affine point
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] x, y, z;
	} point_req_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic        sat;
	} point_res_t;

	typedef struct {
		point_req_t req;
		logic       known;
		point_res_t res;
	} vector_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = hpt_pkg::MODE_AFFINE;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic done;
	logic signed [31:0] out_x, out_y, out_z;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hpt_pkg::CFG_W-1:0] cfg_data = '0;

	homogeneous_point_transform uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .in_x(in_x), .in_y(in_y), .in_z(in_z),
		.done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.saturated(saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// matrix copy kept in step with accepted register writes
	logic [63:0] matrix_words [0:7];
	point_res_t  pending_points [$];
	vector_row_t directed_rows [$];
	// typed-in expectation for the request being driven
	logic        use_known = 1'b0;
	point_res_t  known_res;
	int mismatches = 0;
	int points_checked = 0;
	int sat_seen = 0;
	int divides_seen = 0;
	int quiet_cycles = 0;

	function automatic logic signed [31:0] coef(int r, int c);
		logic [63:0] w;
		w = matrix_words[r * 2 + c / 2];
		return (c % 2) ? w[63:32] : w[31:0];
	endfunction

	// exact dot product of one column, rounded half up to Q16.16, unsaturated
	function automatic logic signed [79:0] column_q(logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, int c, logic with_t);
		logic signed [79:0] acc, vx, vy, vz, k0, k1, k2, tr;
		vx = x; vy = y; vz = z;
		k0 = coef(0, c); k1 = coef(1, c); k2 = coef(2, c); tr = coef(3, c);
		acc = vx * k0 + vy * k1 + vz * k2;
		if (with_t)
			acc = acc + tr * 80'sd65536;
		return (acc + 80'sd32768) >>> 16;
	endfunction

	function automatic logic [31:0] clamp_q(logic signed [79:0] v, inout logic flag);
		if (v > 80'sd2147483647) begin
			flag = 1'b1;
			return hpt_pkg::Q_MAX;
		end
		if (v < -80'sd2147483648) begin
			flag = 1'b1;
			return hpt_pkg::Q_MIN;
		end
		return v[31:0];
	endfunction

	// (c * 1.0) / w, nearest with ties away from zero, then clamped
	function automatic logic [31:0] persp_divide(logic signed [79:0] c,
			logic signed [79:0] w, inout logic flag);
		logic neg;
		logic [95:0] nc, nw, n, q, r;
		neg = (c < 0) != (w < 0);
		nc = (c < 0) ? 96'(-c) : 96'(c);
		nw = (w < 0) ? 96'(-w) : 96'(w);
		n = nc << 16;
		q = n / nw;
		r = n % nw;
		if (r >= nw - r)
			q = q + 1;
		if (neg) begin
			if (q > 96'd2147483648) begin
				flag = 1'b1;
				return hpt_pkg::Q_MIN;
			end
			return 32'(-q);
		end
		if (q > 96'd2147483647) begin
			flag = 1'b1;
			return hpt_pkg::Q_MAX;
		end
		return q[31:0];
	endfunction

	function automatic point_res_t transform_point(point_req_t p);
		point_res_t res;
		logic signed [79:0] cx, cy, cz, w;
		logic flag;
		logic with_t;
		flag = 1'b0;
		with_t = (p.mode != hpt_pkg::MODE_DIR);
		cx = column_q(p.x, p.y, p.z, 0, with_t);
		cy = column_q(p.x, p.y, p.z, 1, with_t);
		cz = column_q(p.x, p.y, p.z, 2, with_t);
		w = column_q(p.x, p.y, p.z, 3, 1'b1);
		if (p.mode == hpt_pkg::MODE_PERSP && w != 80'sd65536 && w != 0) begin
			res.x = persp_divide(cx, w, flag);
			res.y = persp_divide(cy, w, flag);
			res.z = persp_divide(cz, w, flag);
		end else begin
			res.x = clamp_q(cx, flag);
			res.y = clamp_q(cy, flag);
			res.z = clamp_q(cz, flag);
		end
		res.sat = flag;
		return res;
	endfunction

	// request and result monitor, sampled on the rising edge
	always @(posedge clk) begin
		point_req_t p;
		point_res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready && cfg_index < hpt_pkg::NREG)
				matrix_words[cfg_index] <= cfg_data;
			if (start && !busy) begin
				p.mode = req_type;
				p.x = in_x; p.y = in_y; p.z = in_z;
				if (use_known)
					pending_points.push_back(known_res);
				else
					pending_points.push_back(transform_point(p));
				if (req_type == hpt_pkg::MODE_PERSP)
					divides_seen++;
			end
			if (done) begin
				if (pending_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h %h %h sat %b",
							out_x, out_y, out_z, saturated);
				end else begin
					want = pending_points.pop_front();
					points_checked++;
					if (saturated)
						sat_seen++;
					if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
							saturated !== want.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h %h %h sat %b, got %h %h %h sat %b",
								want.x, want.y, want.z, want.sat,
								out_x, out_y, out_z, saturated);
					end
				end
			end
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("homogeneous_point_transform_test NOT OK");
				$finish;
			end
		end
	end

	// one request; the sender may first go idle, with a chance of idle_pct percent
	task automatic send_point(point_req_t p, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= p.mode;
		in_x <= p.x; in_y <= p.y; in_z <= p.z;
		do
			@(posedge clk);
		while (!(start && !busy));
	endtask

	// stop sending and let the pipeline run empty
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (hpt_pkg::LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx[hpt_pkg::CFG_IDX_W-1:0];
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h000A_0000)) - 32'h0005_0000;
			2: return ($urandom_range(1)) ? hpt_pkg::Q_MAX : hpt_pkg::Q_MIN;
			3: return ($urandom_range(1)) ? Q_ONE_C : -Q_ONE_C;
			4: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
			default: return 32'($urandom_range(0, 65535)) - 32'd32768;
		endcase
	endfunction

	function automatic logic [31:0] small_q();
		return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
	endfunction

	task automatic load_matrix(mat_kind_e kind);
		logic [31:0] lo, hi;
		for (int i = IDX_R0_C01; i <= IDX_R3_C23; i++) begin
			case (kind)
				MAT_ZERO: begin lo = '0; hi = '0; end
				MAT_ALL_ONES: begin lo = '1; hi = '1; end
				MAT_MAX: begin lo = hpt_pkg::Q_MAX; hi = hpt_pkg::Q_MAX; end
				MAT_MIN: begin lo = hpt_pkg::Q_MIN; hi = hpt_pkg::Q_MIN; end
				MAT_PERSP: begin
					lo = rand_q();
					hi = (i == IDX_R3_C23) ? Q_ONE_C + small_q() : small_q();
				end
				MAT_W_ZERO: begin
					// identity on x, y, z with an all-zero w column
					lo = (i == IDX_R0_C01 || i == IDX_R2_C23) ? Q_ONE_C : '0;
					hi = (i == IDX_R1_C01) ? Q_ONE_C : '0;
				end
				default: begin lo = rand_q(); hi = rand_q(); end
			endcase
			write_reg(i, {hi, lo});
		end
	endtask

	task automatic add_row(logic [1:0] m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic known, logic [31:0] ex, logic [31:0] ey, logic [31:0] ez, logic es);
		vector_row_t row;
		row.req.mode = m; row.req.x = x; row.req.y = y; row.req.z = z;
		row.known = known;
		row.res.x = ex; row.res.y = ey; row.res.z = ez; row.res.sat = es;
		directed_rows.push_back(row);
	endtask

	initial begin
		point_req_t p;
		int idle_pct;
		// identity matrix after reset
		matrix_words[IDX_R0_C01] = 64'd65536;
		matrix_words[IDX_R0_C23] = 64'd0;
		matrix_words[IDX_R1_C01] = 64'd281474976710656;
		matrix_words[IDX_R1_C23] = 64'd0;
		matrix_words[IDX_R2_C01] = 64'd0;
		matrix_words[IDX_R2_C23] = 64'd65536;
		matrix_words[IDX_R3_C01] = 64'd0;
		matrix_words[IDX_R3_C23] = 64'd281474976710656;

		// identity leaves every mode unchanged: w is exactly one, no translation
		add_row(hpt_pkg::MODE_AFFINE, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(hpt_pkg::MODE_AFFINE, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, Q_ONE_C,
			1, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, Q_ONE_C, 0);
		add_row(hpt_pkg::MODE_AFFINE, hpt_pkg::Q_MIN, hpt_pkg::Q_MAX, '1,
			1, hpt_pkg::Q_MIN, hpt_pkg::Q_MAX, '1, 0);
		add_row(hpt_pkg::MODE_PERSP, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX,
			1, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, 0);
		add_row(hpt_pkg::MODE_PERSP, hpt_pkg::Q_MIN, 32'h5555_5555, 32'hAAAA_AAAA,
			1, hpt_pkg::Q_MIN, 32'h5555_5555, 32'hAAAA_AAAA, 0);
		add_row(hpt_pkg::MODE_DIR, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN,
			1, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, 0);
		add_row(hpt_pkg::MODE_DIR, 32'h1234_5678, -Q_ONE_C, 1,
			1, 32'h1234_5678, -Q_ONE_C, 1, 0);
		add_row(MODE_UNUSED, hpt_pkg::Q_MAX, 0, hpt_pkg::Q_MIN,
			1, hpt_pkg::Q_MAX, 0, hpt_pkg::Q_MIN, 0);
		add_row(MODE_UNUSED, 32'hFFFF_8000, 32'h0000_8000, 7,
			1, 32'hFFFF_8000, 32'h0000_8000, 7, 0);
		add_row(hpt_pkg::MODE_PERSP, 1, -1, 32'h7FFF_0000, 0, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			use_known <= directed_rows[i].known;
			known_res <= directed_rows[i].res;
			send_point(directed_rows[i].req, 0);
		end
		use_known <= 1'b0;
		drain_pipe();

		// scaled matrix, so saturation and rounding show up in directed rows
		write_reg(IDX_R0_C01, {32'h0000_0000, 32'h0002_0000});
		write_reg(IDX_R1_C01, {32'hFFFE_0000, 32'h0000_0000});
		write_reg(IDX_R2_C23, {32'h0000_0000, 32'h0000_8000});
		write_reg(IDX_R3_C01, {32'h0000_0001, 32'h8000_0000});
		write_reg(IDX_R3_C23, {32'h0002_0000, 32'h0000_0000});
		// indexes past the matrix are ignored
		for (int i = hpt_pkg::NREG; i < (1 << hpt_pkg::CFG_IDX_W); i++)
			write_reg(i, {$urandom, $urandom});
		// half-unit ties, clamping both ways, divide by two
		directed_rows.delete();
		add_row(hpt_pkg::MODE_AFFINE, hpt_pkg::Q_MAX, hpt_pkg::Q_MAX, 1, 0, 0, 0, 0, 0);
		add_row(hpt_pkg::MODE_AFFINE, hpt_pkg::Q_MIN, hpt_pkg::Q_MIN, 32'hFFFF_FFFF,
			0, 0, 0, 0, 0);
		add_row(hpt_pkg::MODE_PERSP, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, 3, 0, 0, 0, 0, 0);
		add_row(hpt_pkg::MODE_PERSP, 32'h0003_0001, 32'hFFFD_0001, 5, 0, 0, 0, 0, 0);
		add_row(hpt_pkg::MODE_DIR, hpt_pkg::Q_MAX, hpt_pkg::Q_MIN, hpt_pkg::Q_MAX,
			0, 0, 0, 0, 0);
		add_row(MODE_UNUSED, 1, 1, 1, 0, 0, 0, 0, 0);
		foreach (directed_rows[i]) begin
			use_known <= directed_rows[i].known;
			known_res <= directed_rows[i].res;
			send_point(directed_rows[i].req, 0);
		end
		use_known <= 1'b0;
		drain_pipe();

		// random phases: each loads a matrix, then streams points, with idling in some phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_matrix(MAT_RANDOM);
				1: load_matrix(MAT_PERSP);
				2: load_matrix(MAT_ZERO);
				3: load_matrix(MAT_ALL_ONES);
				4: load_matrix(MAT_MAX);
				5: load_matrix(MAT_MIN);
				6: load_matrix(MAT_W_ZERO);
				default: load_matrix(MAT_PERSP);
			endcase
			idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 68 : 31);
			for (int n = 0; n < 90; n++) begin
				p.mode = ($urandom_range(9) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
				p.x = rand_q(); p.y = rand_q(); p.z = rand_q();
				send_point(p, idle_pct);
				// idling is halved for the rest of the phase
				if (n == 45)
					idle_pct = idle_pct / 2;
			end
			// every phase ends by letting all results come back
			drain_pipe();
		end

		$display("checked %0d transformed points (%0d perspective requests, %0d saturated)",
			points_checked, divides_seen, sat_seen);
		$display("matrices covered: identity, scaled, random, zero, extremes, w of zero");
		if (mismatches == 0 && pending_points.size() == 0) begin
			$display("homogeneous_point_transform_test OK");
		end else begin
			$display("homogeneous_point_transform_test NOT OK");
		end
		$finish;
	end

endmodule
